// ----- hdl/ild_pkg.sv -----
package ild_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ELEMENT_TYPE = 2'd0;
    localparam logic [1:0] CFG_STEP_SCALE   = 2'd1;
    localparam logic [1:0] CFG_FLOOR_ZERO   = 2'd2;
    localparam logic [1:0] CFG_STORE_VALUES = 2'd3;

    // Element size codes, the low two bits of element_type.
    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;
    localparam logic [1:0] SIZE_64 = 2'd3;

    // Bit of element_type that selects a signed element.
    localparam int TYPE_SIGNED_BIT = 2;

    localparam logic [2:0]  ELEMENT_TYPE_RESET = 3'd0;
    localparam logic [63:0] STEP_SCALE_RESET   = 64'd1;

    // All ones over the element width.
    function automatic logic [63:0] width_mask(input logic [1:0] size);
        logic [63:0] m;
        unique case (size)
            SIZE_8:  m = 64'h0000_0000_0000_00ff;
            SIZE_16: m = 64'h0000_0000_0000_ffff;
            SIZE_32: m = 64'h0000_0000_ffff_ffff;
            SIZE_64: m = 64'hffff_ffff_ffff_ffff;
            default: m = 64'hffff_ffff_ffff_ffff;
        endcase
        return m;
    endfunction

    // Sign bit of the element, which is also MAX+1 of the signed type.
    function automatic logic [63:0] sign_bit(input logic [1:0] size);
        logic [63:0] t;
        unique case (size)
            SIZE_8:  t = 64'h0000_0000_0000_0080;
            SIZE_16: t = 64'h0000_0000_0000_8000;
            SIZE_32: t = 64'h0000_0000_8000_0000;
            SIZE_64: t = 64'h8000_0000_0000_0000;
            default: t = 64'h8000_0000_0000_0000;
        endcase
        return t;
    endfunction

endpackage

// ----- hdl/integer_linear_dequantizer.sv -----
// Integer linear dequantizer.
//
// Requests enter on start together with quant_word and last_in. A request is
// taken at every rising edge where start is high and busy is low; busy is
// held low, so a new request may arrive in every cycle and the block runs at
// one element per clock.
// Each request produces exactly one result, shown on decoded_word and
// last_out for a single cycle with done high. The request passes the stage
// registers s1 to s5 and then the output register, which drives done.
// The receiver cannot hold results off, and nothing inside waits.
// The six register stages are set by the 64 by 64 bit multiply: operand
// preparation, four 32 by 32 partial products, two adds to form the 128-bit
// product, saturation, and the final sign and clamp stage.
// Configuration is written through cfg_we, cfg_index and cfg_wdata and takes
// effect at once; the user must change it only while no request is in flight,
// which the block itself does not enforce. An asynchronous reset on rst_n
// empties the pipeline (no done follows) and restores element_type 0 (unsigned
// 8 bit), step_scale 1, floor_zero 0 and store_values 0.
module integer_linear_dequantizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] quant_word,
    input  logic        last_in,
    output logic        done,
    output logic [63:0] decoded_word,
    output logic        last_out,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);

    // Configuration registers.
    logic [2:0]  element_type_reg, element_type_next;
    logic [63:0] step_scale_reg, step_scale_next;
    logic        floor_zero_reg, floor_zero_next;
    logic        store_values_reg, store_values_next;

    // Decoded view of the element type. The user keeps configuration static while
    // requests are in flight (the block does not enforce it); stages read it directly.
    logic [1:0]  size;
    logic        is_signed;
    logic [63:0] mask;
    logic [63:0] top;

    // Valid bits travelling with the data.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic out_valid_reg;
    logic accept;

    // Stage 1: masked element, its magnitude and its sign.
    logic [63:0] s1_x_reg, s1_x_next;
    logic [63:0] s1_mag_reg, s1_mag_next;
    logic        s1_neg_reg, s1_neg_next;
    logic        s1_last_reg;

    // Stage 2: partial products of magnitude and step.
    logic [63:0] s2_ll_reg, s2_ll_next;
    logic [63:0] s2_lh_reg, s2_lh_next;
    logic [63:0] s2_hl_reg, s2_hl_next;
    logic [63:0] s2_hh_reg, s2_hh_next;
    logic [63:0] s2_x_reg;
    logic        s2_neg_reg, s2_last_reg;

    // Stage 3: the two middle partial products summed.
    logic [64:0] s3_mid_reg, s3_mid_next;
    logic [63:0] s3_ll_reg, s3_hh_reg, s3_x_reg;
    logic        s3_neg_reg, s3_last_reg;

    // Stage 4: full 128-bit product.
    logic [127:0] s4_prod_reg, s4_prod_next;
    logic [63:0]  s4_x_reg;
    logic         s4_neg_reg, s4_last_reg;

    // Stage 5: product saturated at the type maximum (unsigned) or at MAX+1
    // (signed magnitude).
    logic [63:0] s5_mr_reg, s5_mr_next;
    logic [63:0] s5_x_reg;
    logic        s5_neg_reg, s5_last_reg;

    // Output register.
    logic [63:0] out_word_reg, out_word_next;
    logic        out_last_reg;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    assign size      = element_type_reg[1:0];
    assign is_signed = element_type_reg[ild_pkg::TYPE_SIGNED_BIT];
    assign mask      = ild_pkg::width_mask(size);
    assign top       = ild_pkg::sign_bit(size);

    // Configuration writes.
    always_comb
    begin
        element_type_next = element_type_reg;
        step_scale_next   = step_scale_reg;
        floor_zero_next   = floor_zero_reg;
        store_values_next = store_values_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                ild_pkg::CFG_ELEMENT_TYPE: element_type_next = cfg_wdata[2:0];
                ild_pkg::CFG_STEP_SCALE:   step_scale_next   = cfg_wdata;
                ild_pkg::CFG_FLOOR_ZERO:   floor_zero_next   = cfg_wdata[0];
                ild_pkg::CFG_STORE_VALUES: store_values_next = cfg_wdata[0];
                default:                   element_type_next = element_type_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_type_reg <= ild_pkg::ELEMENT_TYPE_RESET;
            step_scale_reg   <= ild_pkg::STEP_SCALE_RESET;
            floor_zero_reg   <= 1'b0;
            store_values_reg <= 1'b0;
        end
        else
        begin
            element_type_reg <= element_type_next;
            step_scale_reg   <= step_scale_next;
            floor_zero_reg   <= floor_zero_next;
            store_values_reg <= store_values_next;
        end
    end

    // Valid chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            out_valid_reg <= s5_valid_reg;
        end
    end

    // Stage 1: bits above the element width are dropped. A signed negative
    // element is negated so the multiply only sees magnitudes; the most
    // negative element gives exactly MAX+1.
    always_comb
    begin
        s1_x_next   = quant_word & mask;
        s1_neg_next = is_signed && ((s1_x_next & top) != 64'd0);
        s1_mag_next = s1_neg_next ? ((~s1_x_next + 64'd1) & mask) : s1_x_next;
    end

    // Stage 2: four independent 32 by 32 multipliers.
    always_comb
    begin
        s2_ll_next = 64'(s1_mag_reg[31:0])  * 64'(step_scale_reg[31:0]);
        s2_lh_next = 64'(s1_mag_reg[31:0])  * 64'(step_scale_reg[63:32]);
        s2_hl_next = 64'(s1_mag_reg[63:32]) * 64'(step_scale_reg[31:0]);
        s2_hh_next = 64'(s1_mag_reg[63:32]) * 64'(step_scale_reg[63:32]);
    end

    assign s3_mid_next  = {1'b0, s2_lh_reg} + {1'b0, s2_hl_reg};
    assign s4_prod_next = {s3_hh_reg, s3_ll_reg} + {31'd0, s3_mid_reg, 32'd0};

    // Stage 5: saturation. A zero step yields a zero product and never
    // saturates.
    always_comb
    begin
        logic [63:0] cap;
        cap = is_signed ? top : mask;
        if (s4_prod_reg > {64'd0, cap})
        begin
            s5_mr_next = cap;
        end
        else
        begin
            s5_mr_next = s4_prod_reg[63:0];
        end
    end

    // Output stage: stored values are copied, indexes take the saturated
    // product. Signed results get their sign back, are floored at zero when
    // asked, and a positive result of MAX+1 clamps to MAX.
    always_comb
    begin
        if (store_values_reg)
        begin
            if (s5_neg_reg && floor_zero_reg)
            begin
                out_word_next = 64'd0;
            end
            else
            begin
                out_word_next = s5_x_reg;
            end
        end
        else if (!is_signed)
        begin
            out_word_next = s5_mr_reg;
        end
        else if (s5_neg_reg)
        begin
            out_word_next = floor_zero_reg ? 64'd0 : ((~s5_mr_reg + 64'd1) & mask);
        end
        else if (s5_mr_reg == top)
        begin
            out_word_next = top - 64'd1;
        end
        else
        begin
            out_word_next = s5_mr_reg;
        end
    end

    // Data path registers; they need no reset since the valid bits guard them.
    always_ff @(posedge clk)
    begin
        s1_x_reg     <= s1_x_next;
        s1_mag_reg   <= s1_mag_next;
        s1_neg_reg   <= s1_neg_next;
        s1_last_reg  <= last_in;

        s2_ll_reg    <= s2_ll_next;
        s2_lh_reg    <= s2_lh_next;
        s2_hl_reg    <= s2_hl_next;
        s2_hh_reg    <= s2_hh_next;
        s2_x_reg     <= s1_x_reg;
        s2_neg_reg   <= s1_neg_reg;
        s2_last_reg  <= s1_last_reg;

        s3_mid_reg   <= s3_mid_next;
        s3_ll_reg    <= s2_ll_reg;
        s3_hh_reg    <= s2_hh_reg;
        s3_x_reg     <= s2_x_reg;
        s3_neg_reg   <= s2_neg_reg;
        s3_last_reg  <= s2_last_reg;

        s4_prod_reg  <= s4_prod_next;
        s4_x_reg     <= s3_x_reg;
        s4_neg_reg   <= s3_neg_reg;
        s4_last_reg  <= s3_last_reg;

        s5_mr_reg    <= s5_mr_next;
        s5_x_reg     <= s4_x_reg;
        s5_neg_reg   <= s4_neg_reg;
        s5_last_reg  <= s4_last_reg;

        out_word_reg <= out_word_next;
        out_last_reg <= s5_last_reg;
    end

    assign done         = out_valid_reg;
    assign decoded_word = out_word_reg;
    assign last_out     = out_last_reg;

endmodule

// ----- tb/dequant_checker.sv -----
module dequant_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [63:0] quant_word,
    input  logic        last_in,
    input  logic        done,
    input  logic [63:0] decoded_word,
    input  logic        last_out,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    output int          fail_count,
    output int          in_flight
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [63:0] word;
        logic        last;
    } decoded_t;

    // Local copy of the configuration, updated from the write port.
    logic [2:0]  cur_type;
    logic [63:0] cur_step;
    logic        cur_floor;
    logic        cur_store;

    decoded_t decoded_due[$];
    decoded_t due;
    decoded_t fresh;
    int       errors = 0;
    int       results_seen = 0;

    assign fail_count = errors;

    // Rebuilds one element; a 128-bit product makes the saturation test exact.
    function automatic logic [63:0] dequantize(input logic [63:0] raw,
                                               input logic [2:0]  etype,
                                               input logic [63:0] step,
                                               input logic        zero_floor,
                                               input logic        stored);
        logic [63:0]  mask;
        logic [63:0]  top;
        logic [63:0]  hi;
        logic [63:0]  x;
        logic [63:0]  mag;
        logic [63:0]  mr;
        logic [63:0]  r;
        logic [127:0] prod;
        logic         neg;
        case (etype[1:0])
            ild_pkg::SIZE_8:  mask = 64'h0000_0000_0000_00ff;
            ild_pkg::SIZE_16: mask = 64'h0000_0000_0000_ffff;
            ild_pkg::SIZE_32: mask = 64'h0000_0000_ffff_ffff;
            default:          mask = 64'hffff_ffff_ffff_ffff;
        endcase
        top = (mask >> 1) + 64'd1;
        hi  = top - 64'd1;
        x   = raw & mask;
        neg = (x & top) != 64'd0;
        if (!etype[ild_pkg::TYPE_SIGNED_BIT]) begin
            if (stored) begin
                r = x;
            end else begin
                prod = {64'd0, x} * {64'd0, step};
                r = (prod > {64'd0, mask}) ? mask : prod[63:0];
            end
        end else if (stored) begin
            r = (neg && zero_floor) ? 64'd0 : x;
        end else begin
            mag  = neg ? ((~x + 64'd1) & mask) : x;
            prod = {64'd0, mag} * {64'd0, step};
            mr   = (prod > {64'd0, top}) ? top : prod[63:0];
            if (neg)
                r = zero_floor ? 64'd0 : ((~mr + 64'd1) & mask);
            else
                r = (mr > hi) ? hi : mr;
        end
        return r & mask;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cur_type  = ild_pkg::ELEMENT_TYPE_RESET;
            cur_step  = ild_pkg::STEP_SCALE_RESET;
            cur_floor = 1'b0;
            cur_store = 1'b0;
            decoded_due.delete();
            in_flight <= 0;
        end else begin
            if (done) begin
                results_seen++;
                if (decoded_due.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("result %0d with no request pending: word %h last %b",
                                 results_seen, decoded_word, last_out);
                end else begin
                    due = decoded_due.pop_front();
                    if (decoded_word !== due.word || last_out !== due.last) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("result %0d: expected word %h last %b, got word %h last %b",
                                     results_seen, due.word, due.last, decoded_word, last_out);
                    end
                end
            end
            // The request is predicted with the settings in force before any write
            // at this same edge.
            if (start && !busy) begin
                fresh.word = dequantize(quant_word, cur_type, cur_step, cur_floor, cur_store);
                fresh.last = last_in;
                decoded_due.push_back(fresh);
            end
            if (cfg_we) begin
                case (cfg_index)
                    ild_pkg::CFG_ELEMENT_TYPE: cur_type  = cfg_wdata[2:0];
                    ild_pkg::CFG_STEP_SCALE:   cur_step  = cfg_wdata;
                    ild_pkg::CFG_FLOOR_ZERO:   cur_floor = cfg_wdata[0];
                    ild_pkg::CFG_STORE_VALUES: cur_store = cfg_wdata[0];
                    default: ;
                endcase
            end
            in_flight <= decoded_due.size();
        end
    end

endmodule

// ----- tb/integer_linear_dequantizer_tb.sv -----
module integer_linear_dequantizer_tb;

    // Number of cycles in which nothing at all is taken before the run is
    // declared hung. The longest legal silence is a long sender gap, or the
    // pipeline plus the settle time.
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int RESET_CYCLES    = 10;
    // A little more than the request-to-result latency.
    localparam int SETTLE_CYCLES   = 8;
    localparam int PHASES          = 30;
    localparam int ITEMS_PER_PHASE = 50;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [63:0] quant_word = 64'd0;
    logic        last_in = 1'b0;
    logic        done;
    logic [63:0] decoded_word;
    logic        last_out;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = ild_pkg::CFG_ELEMENT_TYPE;
    logic [63:0] cfg_wdata = 64'd0;

    int fail_count;
    int in_flight;
    int quiet_cycles = 0;

    // The element type and step currently programmed, so that random elements
    // can be aimed at the saturation edges of the present setting.
    logic [2:0]  now_type = ild_pkg::ELEMENT_TYPE_RESET;
    logic [63:0] now_step = ild_pkg::STEP_SCALE_RESET;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    integer_linear_dequantizer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .quant_word   (quant_word),
        .last_in      (last_in),
        .done         (done),
        .decoded_word (decoded_word),
        .last_out     (last_out),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    // The checker watches both channels and the write port, predicts every
    // result and compares; this module only makes stimulus and judges.
    dequant_checker scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .quant_word   (quant_word),
        .last_in      (last_in),
        .done         (done),
        .decoded_word (decoded_word),
        .last_out     (last_out),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .in_flight    (in_flight)
    );

    // Watchdog: any taken request, any result or any register write counts as
    // progress; a long stretch without one means the block has hung.
    always @(posedge clk) begin
        if ((start && !busy) || done || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("integer_linear_dequantizer verification failed");
            $finish;
        end
    end

    // Sender gap lengths: mostly none or short, now and then a long one.
    function automatic int idle_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] size_mask(input logic [1:0] size);
        case (size)
            ild_pkg::SIZE_8:  return 64'h0000_0000_0000_00ff;
            ild_pkg::SIZE_16: return 64'h0000_0000_0000_ffff;
            ild_pkg::SIZE_32: return 64'h0000_0000_ffff_ffff;
            default:          return 64'hffff_ffff_ffff_ffff;
        endcase
    endfunction

    // Picks an element for the present type. The bits above the element width
    // are always random, since the block has to ignore them.
    function automatic logic [63:0] pick_element(input logic [2:0]  etype,
                                                 input logic [63:0] step);
        logic [63:0] mask;
        logic [63:0] top;
        logic [63:0] base;
        logic [63:0] noise;
        mask  = size_mask(etype[1:0]);
        top   = (mask >> 1) + 64'd1;
        noise = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: base = noise;
            1: begin
                case ($urandom_range(0, 7))
                    0: base = 64'd0;
                    1: base = 64'd1;
                    2: base = top - 64'd1;
                    3: base = top;
                    4: base = top + 64'd1;
                    5: base = mask;
                    6: base = mask - 64'd1;
                    default: base = top >> 1;
                endcase
            end
            2: base = 64'($urandom_range(0, 15));
            3: base = mask - 64'($urandom_range(0, 15));
            4: begin
                // Right at the saturation threshold or one past it, with
                // either sign for signed types.
                if (step == 64'd0)
                    base = 64'($urandom_range(0, 3));
                else if (etype[ild_pkg::TYPE_SIGNED_BIT])
                    base = top / step + 64'($urandom_range(0, 1));
                else
                    base = mask / step + 64'($urandom_range(0, 1));
                if (etype[ild_pkg::TYPE_SIGNED_BIT] && $urandom_range(0, 1) == 1)
                    base = ~base + 64'd1;
            end
            default: base = noise & (mask >> $urandom_range(0, 63));
        endcase
        return (noise & ~mask) | (base & mask);
    endfunction

    // Steps: zero, one, small, powers of two, full random and the extremes.
    function automatic logic [63:0] pick_step();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return 64'd1;
            2: return 64'($urandom_range(2, 16));
            3: return 64'd1 << $urandom_range(0, 63);
            4: return {$urandom, $urandom};
            5: return 64'hffff_ffff_ffff_ffff;
            6: return size_mask(2'($urandom_range(0, 3)));
            default: return {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
    endfunction

    // Presents one request and returns at the edge that takes it. When a gap
    // follows, start drops for that many cycles; otherwise it stays high so
    // the next request follows back to back.
    task automatic send(input logic [63:0] word, input logic last, input int gap);
        start      <= 1'b1;
        quant_word <= word;
        last_in    <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops sending and waits until every request in flight has produced its
    // result, then lets the pipeline settle.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    // Reprograms all four registers once the block is idle. The narrow
    // registers get random junk in the unused upper bits of the write data.
    task automatic set_config(input logic [2:0]  etype,
                              input logic [63:0] step,
                              input logic        zero_floor,
                              input logic        stored);
        wait_idle();
        write_reg(ild_pkg::CFG_ELEMENT_TYPE, ({$urandom, $urandom} & ~64'h7) | etype);
        write_reg(ild_pkg::CFG_STEP_SCALE, step);
        write_reg(ild_pkg::CFG_FLOOR_ZERO, ({$urandom, $urandom} & ~64'h1) | zero_floor);
        write_reg(ild_pkg::CFG_STORE_VALUES, ({$urandom, $urandom} & ~64'h1) | stored);
        cfg_we   <= 1'b0;
        now_type = etype;
        now_step = step;
    endtask

    initial begin
        logic        burst;
        logic [2:0]  etype;
        logic [63:0] step;
        logic        zero_floor;
        logic        stored;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests. Reset settings first: unsigned 8 bit, step one,
        // including junk in the upper bits of the input word.
        send(64'h0, 1'b0, idle_cycles());
        send(64'hff, 1'b1, idle_cycles());
        send(64'hffff_ffff_ffff_ffff, 1'b0, idle_cycles());
        send(64'h80, 1'b1, idle_cycles());

        // Unsigned product exactly at the maximum, then one step over it.
        set_config(3'd0, 64'd3, 1'b0, 1'b0);
        send(64'h55, 1'b0, idle_cycles());
        send(64'h56, 1'b1, idle_cycles());

        // A zero step gives zero in index mode.
        set_config(3'd1, 64'd0, 1'b0, 1'b0);
        send(64'hffff, 1'b0, idle_cycles());
        send(64'h1234, 1'b1, idle_cycles());

        // Signed 8 bit: the minimum, positive saturation, a product landing
        // on the minimum, negative saturation and a plain case.
        set_config(3'd4, 64'd2, 1'b0, 1'b0);
        send(64'h80, 1'b0, idle_cycles());
        send(64'h7f, 1'b1, idle_cycles());
        send(64'hc0, 1'b0, idle_cycles());
        send(64'hbf, 1'b1, idle_cycles());
        send(64'h01, 1'b0, idle_cycles());

        // Zero floor on signed index mode.
        set_config(3'd4, 64'd2, 1'b1, 1'b0);
        send(64'h80, 1'b1, idle_cycles());
        send(64'h05, 1'b0, idle_cycles());

        // Stored values: unsigned 64 bit copies, signed 16 bit with and
        // without the zero floor.
        set_config(3'd3, 64'd5, 1'b0, 1'b1);
        send(64'hffff_ffff_ffff_ffff, 1'b1, idle_cycles());
        set_config(3'd5, 64'd1, 1'b1, 1'b1);
        send(64'h8000, 1'b0, idle_cycles());
        send(64'h7fff, 1'b1, idle_cycles());
        set_config(3'd5, 64'd1, 1'b0, 1'b1);
        send(64'h8000, 1'b0, idle_cycles());

        // Largest step on the 64-bit types.
        set_config(3'd7, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b0);
        send(64'h1, 1'b1, idle_cycles());
        send(64'hffff_ffff_ffff_ffff, 1'b0, idle_cycles());
        send(64'h8000_0000_0000_0000, 1'b1, idle_cycles());
        set_config(3'd3, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b0);
        send(64'h1, 1'b0, idle_cycles());
        send(64'h2, 1'b1, idle_cycles());

        // Negative element under a zero step with the zero floor set.
        set_config(3'd6, 64'd0, 1'b1, 1'b0);
        send(64'hffff_ffff, 1'b0, idle_cycles());

        // Random phases, each under its own settings. The first few pin the
        // extreme corners; about a quarter of the phases run without gaps.
        for (int p = 0; p < PHASES; p++) begin
            etype      = 3'($urandom_range(0, 7));
            step       = pick_step();
            zero_floor = 1'($urandom_range(0, 1));
            stored     = ($urandom_range(0, 3) == 0);
            if (p == 0) begin
                etype = 3'd7;
                step  = 64'hffff_ffff_ffff_ffff;
            end else if (p == 1) begin
                etype = 3'd0;
                step  = 64'd0;
            end else if (p == 2) begin
                etype  = 3'd3;
                step   = 64'hffff_ffff_ffff_ffff;
                stored = 1'b0;
            end
            set_config(etype, step, zero_floor, stored);
            burst = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // Now and then the sender holds off until the pipeline is empty.
                if ($urandom_range(0, 199) == 0)
                    wait_idle();
                send(pick_element(now_type, now_step), $urandom_range(0, 7) == 0,
                     burst ? 0 : idle_cycles());
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && in_flight == 0)
            $display("integer_linear_dequantizer verification clean");
        else
            $display("integer_linear_dequantizer verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/ild_pkg.sv
hdl/integer_linear_dequantizer.sv
tb/dequant_checker.sv
tb/integer_linear_dequantizer_tb.sv
